FILE: rtl/iee_pkg.sv
// Shared types, character codes and tables for the infix expression evaluator.
package iee_pkg;

  // ASCII codes the parser recognizes
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // Fraction digit counter width and decimal scale table
  localparam int FRAC_CNT_W = 3;
  localparam int POW10_W    = 24;
  localparam logic [POW10_W-1:0] POW10 [8] = '{
    24'd1, 24'd10, 24'd100, 24'd1000,
    24'd10000, 24'd100000, 24'd1000000, 24'd10000000
  };

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_CONV,
    S_CONV_WAIT,
    S_APPLY,
    S_ARITH_WAIT,
    S_FIN
  } ctl_state_t;

  // Shared unit states
  typedef enum logic [1:0] {
    U_IDLE,
    U_RUN,
    U_FIN
  } unit_state_t;

  typedef enum logic {
    ALU_MUL,
    ALU_DIV
  } alu_op_t;

  // Sequencer to shared unit
  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_req_t;

  // Shared unit to sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } alu_sts_t;

endpackage

FILE: rtl/iee_unit.sv
// Shared iterative unit: shift-add multiply and restoring divide on one adder.
module iee_unit #(
  parameter int VALUE_BITS = 48,
  parameter int FRAC_BITS  = 16,
  localparam int NUM_W = VALUE_BITS + FRAC_BITS,
  localparam int MUL_W = 2 * VALUE_BITS + 1 - FRAC_BITS,
  localparam int RES_W = (MUL_W > NUM_W) ? MUL_W : NUM_W
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  iee_pkg::alu_req_t     req,
  input  logic [VALUE_BITS-1:0] a_in,   // multiplier or dividend magnitude
  input  logic [VALUE_BITS-1:0] b_in,   // multiplicand or divisor magnitude
  output iee_pkg::alu_sts_t     sts,
  output logic [RES_W-1:0]      res     // rounded, unsaturated magnitude
);
  import iee_pkg::*;

  localparam int CNT_W = $clog2(NUM_W + 1);
  localparam int ADD_W = VALUE_BITS + 2;

  unit_state_t             ust_r, ust_nxt;
  alu_op_t                 op_r, op_nxt;
  logic [VALUE_BITS:0]     acc_r, acc_nxt;
  logic [NUM_W-1:0]        quo_r, quo_nxt;
  logic [VALUE_BITS-1:0]   dvs_r, dvs_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [RES_W-1:0]        res_r, res_nxt;
  logic                    done_r, done_nxt;

  logic [VALUE_BITS:0]     shl_rem;
  logic [ADD_W-1:0]        add_a, add_b, add_s;
  logic                    add_sub;
  logic                    no_borrow;

  // Next state
  always_comb begin
    ust_nxt = ust_r;
    unique case (ust_r)
      U_IDLE: if (req.start) ust_nxt = U_RUN;
      U_RUN:  if (cnt_r == CNT_W'(1)) ust_nxt = U_FIN;
      U_FIN:  ust_nxt = U_IDLE;
      default: ust_nxt = U_IDLE;
    endcase
  end

  // Shared adder operands
  always_comb begin
    shl_rem = {acc_r[VALUE_BITS-1:0], quo_r[NUM_W-1]};
    if (op_r == ALU_DIV) begin
      add_a   = {1'b0, shl_rem};
      add_b   = ADD_W'(dvs_r);
      add_sub = 1'b1;
    end else begin
      add_a   = {1'b0, acc_r};
      add_b   = quo_r[0] ? ADD_W'(dvs_r) : '0;
      add_sub = 1'b0;
    end
    add_s     = add_a + (add_sub ? ~add_b : add_b) + ADD_W'(add_sub);
    no_borrow = ~add_s[ADD_W-1];
  end

  // Datapath next values
  always_comb begin
    op_nxt   = op_r;
    acc_nxt  = acc_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    res_nxt  = res_r;
    done_nxt = 1'b0;
    unique case (ust_r)
      U_IDLE: begin
        if (req.start) begin
          op_nxt  = req.op;
          acc_nxt = '0;
          dvs_nxt = b_in;
          if (req.op == ALU_DIV) begin
            // numerator carries the half-divisor rounding term
            quo_nxt = (NUM_W'(a_in) << FRAC_BITS) + NUM_W'(b_in >> 1);
            cnt_nxt = CNT_W'(NUM_W);
          end else begin
            quo_nxt = NUM_W'(a_in);
            cnt_nxt = CNT_W'(VALUE_BITS);
          end
        end
      end
      U_RUN: begin
        cnt_nxt = cnt_r - CNT_W'(1);
        if (op_r == ALU_DIV) begin
          acc_nxt = no_borrow ? add_s[VALUE_BITS:0] : shl_rem;
          quo_nxt = {quo_r[NUM_W-2:0], no_borrow};
        end else begin
          acc_nxt = add_s[ADD_W-1:1];
          quo_nxt = {quo_r[NUM_W-1:VALUE_BITS], add_s[0], quo_r[VALUE_BITS-1:1]};
        end
      end
      U_FIN: begin
        done_nxt = 1'b1;
        if (op_r == ALU_MUL) begin
          // drop fraction bits, round half away from zero on the magnitude
          res_nxt = RES_W'({acc_r, quo_r[VALUE_BITS-1:FRAC_BITS]})
                  + RES_W'(quo_r[FRAC_BITS-1]);
        end else begin
          res_nxt = RES_W'(quo_r);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ust_r  <= U_IDLE;
      done_r <= 1'b0;
      op_r   <= ALU_MUL;
      cnt_r  <= '0;
    end else begin
      ust_r  <= ust_nxt;
      done_r <= done_nxt;
      op_r   <= op_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
    res_r <= res_nxt;
  end

  assign sts.busy = (ust_r != U_IDLE);
  assign sts.done = done_r;
  assign res      = res_r;

endmodule

FILE: rtl/infix_expression_evaluator.sv
// Infix evaluator: a digit or '.' is folded into the pending number as it is taken; an operator
// scales the pending number, then runs a multiply when it closes a '*' and a divide when it
// closes a '/' with a nonzero divisor. Both come from the one shared multiply/divide unit, one bit per cycle.
// The last character then loads the output register, held back while the previous
// result still waits; input is taken only between characters.
// Synchronous active-low reset clears all expression state.
module infix_expression_evaluator #(
  parameter int FRAC_BITS       = 16,
  parameter int VALUE_BITS      = 48,
  parameter int MAX_FRAC_DIGITS = 5
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [7:0]                           in_tdata,   // [7:0] ch
  input  logic                                 in_tlast,   // last
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [((VALUE_BITS+7)/8)*8-1:0]      out_tdata,  // value, zero filled
  output logic [1:0]                           out_tuser   // [0] div_by_zero, [1] overflow
);
  import iee_pkg::*;

  localparam int OUT_W = ((VALUE_BITS + 7) / 8) * 8;
  localparam int VB    = VALUE_BITS;
  localparam int MW    = VALUE_BITS - 1;
  localparam int NUM_W = VALUE_BITS + FRAC_BITS;
  localparam int MUL_W = 2 * VALUE_BITS + 1 - FRAC_BITS;
  localparam int RES_W = (MUL_W > NUM_W) ? MUL_W : NUM_W;

  localparam logic [VB-1:0]    VMAX    = {1'b0, {(VB-1){1'b1}}};
  localparam logic [VB-1:0]    VMIN    = {1'b1, {(VB-1){1'b0}}};
  localparam logic [RES_W-1:0] LIM_POS = RES_W'(VMAX);
  localparam logic [RES_W-1:0] LIM_NEG = RES_W'(VMAX) + RES_W'(1);

  ctl_state_t             state_r, state_nxt;
  logic [VB-1:0]          closed_sum_r, closed_sum_nxt;
  logic [VB-1:0]          last_term_r, last_term_nxt;
  logic [MW-1:0]          mant_r, mant_nxt;
  logic                   frac_mode_r, frac_mode_nxt;
  logic [FRAC_CNT_W-1:0]  frac_cnt_r, frac_cnt_nxt;
  logic [7:0]             pend_op_r, pend_op_nxt;
  logic [7:0]             next_op_r, next_op_nxt;
  logic                   fin_r, fin_nxt;
  logic                   err_div_r, err_div_nxt;
  logic                   err_ovf_r, err_ovf_nxt;
  logic [VB-1:0]          num_r, num_nxt;
  logic                   neg_r, neg_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [VB-1:0]          out_value_r, out_value_nxt;
  logic                   out_dbz_r, out_dbz_nxt;
  logic                   out_ovf_r, out_ovf_nxt;

  logic                   in_xfer;
  logic                   is_digit, is_point;
  logic [3:0]             digit;
  logic [VB+2:0]          mant_x10;
  logic [VB:0]            sum_ext;
  logic                   sum_ovf;
  logic [VB-1:0]          sum_val;
  logic [VB-1:0]          mag_last;
  logic                   apply_arith;
  logic                   out_free;
  logic                   conv_ovf, arith_ovf;
  logic [VB-1:0]          conv_val, arith_val, dz_val;

  alu_req_t               alu_req;
  alu_sts_t               alu_sts;
  logic [VB-1:0]          alu_a, alu_b;
  logic [RES_W-1:0]       alu_res;

  iee_unit #(
    .VALUE_BITS (VALUE_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_unit (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (alu_req),
    .a_in  (alu_a),
    .b_in  (alu_b),
    .sts   (alu_sts),
    .res   (alu_res)
  );

  // Character classes and decimal accumulate (m*10 + d by shifts)
  assign in_xfer  = in_tvalid & in_tready;
  assign is_digit = (in_tdata >= CH_ZERO) && (in_tdata <= CH_NINE);
  assign is_point = (in_tdata == CH_POINT);
  assign digit    = 4'(in_tdata - CH_ZERO);
  assign mant_x10 = ({4'b0, mant_r} << 3) + ({4'b0, mant_r} << 1) + (VB+3)'(digit);

  // Saturating closed_sum + last_term, shared by term push and final result
  assign sum_ext = {closed_sum_r[VB-1], closed_sum_r} + {last_term_r[VB-1], last_term_r};
  assign sum_ovf = sum_ext[VB] ^ sum_ext[VB-1];
  assign sum_val = sum_ovf ? (sum_ext[VB] ? VMIN : VMAX) : sum_ext[VB-1:0];

  assign mag_last = last_term_r[VB-1] ? (~last_term_r + VB'(1)) : last_term_r;

  // Saturation of unit results
  assign conv_ovf  = alu_res > LIM_POS;
  assign conv_val  = conv_ovf ? VMAX : alu_res[VB-1:0];
  assign arith_ovf = alu_res > (neg_r ? LIM_NEG : LIM_POS);
  assign arith_val = arith_ovf ? (neg_r ? VMIN : VMAX)
                   : (neg_r ? (~alu_res[VB-1:0] + VB'(1)) : alu_res[VB-1:0]);

  // Zero divisor: sign of the dividend picks the limit; a zero dividend gives zero
  assign dz_val = last_term_r[VB-1] ? VMIN : ((last_term_r != '0) ? VMAX : '0);

  assign apply_arith = (pend_op_r == CH_STAR) || ((pend_op_r == CH_SLASH) && (num_r != '0));
  assign out_free    = ~out_valid_r | out_tready;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          if (!is_digit && !is_point) state_nxt = S_CONV;
          else if (in_tlast)          state_nxt = S_FIN;
        end
      end
      S_CONV:       state_nxt = S_CONV_WAIT;
      S_CONV_WAIT:  if (alu_sts.done) state_nxt = S_APPLY;
      S_APPLY: begin
        if (apply_arith) state_nxt = S_ARITH_WAIT;
        else             state_nxt = fin_r ? S_FIN : S_IDLE;
      end
      S_ARITH_WAIT: if (alu_sts.done) state_nxt = fin_r ? S_FIN : S_IDLE;
      S_FIN:        if (out_free) state_nxt = S_IDLE;
      default:      state_nxt = S_IDLE;
    endcase
  end

  // Outputs toward the input channel and the shared unit
  always_comb begin
    in_tready     = (state_r == S_IDLE);
    alu_req.start = (state_r == S_CONV) || ((state_r == S_APPLY) && apply_arith);
    alu_req.op    = ((state_r == S_APPLY) && (pend_op_r == CH_STAR)) ? ALU_MUL : ALU_DIV;
    alu_a         = (state_r == S_CONV) ? {1'b0, mant_r} : mag_last;
    alu_b         = (state_r == S_CONV) ? VB'(POW10[frac_cnt_r]) : num_r;
  end

  // Expression state next values
  always_comb begin
    closed_sum_nxt = closed_sum_r;
    last_term_nxt  = last_term_r;
    mant_nxt       = mant_r;
    frac_mode_nxt  = frac_mode_r;
    frac_cnt_nxt   = frac_cnt_r;
    pend_op_nxt    = pend_op_r;
    next_op_nxt    = next_op_r;
    fin_nxt        = fin_r;
    err_div_nxt    = err_div_r;
    err_ovf_nxt    = err_ovf_r;
    num_nxt        = num_r;
    neg_nxt        = neg_r;
    out_valid_nxt  = out_valid_r & ~out_tready;
    out_value_nxt  = out_value_r;
    out_dbz_nxt    = out_dbz_r;
    out_ovf_nxt    = out_ovf_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          if (is_digit) begin
            // extra fraction digits are dropped
            if (!frac_mode_r || (frac_cnt_r < FRAC_CNT_W'(MAX_FRAC_DIGITS))) begin
              if (mant_x10 > (VB+3)'(VMAX)) begin
                mant_nxt    = VMAX[MW-1:0];
                err_ovf_nxt = 1'b1;
              end else begin
                mant_nxt = mant_x10[MW-1:0];
              end
              if (frac_mode_r) frac_cnt_nxt = frac_cnt_r + FRAC_CNT_W'(1);
            end
          end else if (is_point) begin
            frac_mode_nxt = 1'b1;
          end else begin
            next_op_nxt = in_tdata;
            fin_nxt     = in_tlast;
          end
        end
      end
      S_CONV_WAIT: begin
        if (alu_sts.done) begin
          num_nxt     = conv_val;
          err_ovf_nxt = err_ovf_r | conv_ovf;
        end
      end
      S_APPLY: begin
        mant_nxt      = '0;
        frac_mode_nxt = 1'b0;
        frac_cnt_nxt  = '0;
        pend_op_nxt   = next_op_r;
        neg_nxt       = last_term_r[VB-1];
        unique case (pend_op_r)
          CH_PLUS: begin
            closed_sum_nxt = sum_val;
            err_ovf_nxt    = err_ovf_r | sum_ovf;
            last_term_nxt  = num_r;
          end
          CH_MINUS: begin
            closed_sum_nxt = sum_val;
            err_ovf_nxt    = err_ovf_r | sum_ovf;
            last_term_nxt  = ~num_r + VB'(1);
          end
          CH_SLASH: begin
            if (num_r == '0) begin
              err_div_nxt   = 1'b1;
              last_term_nxt = dz_val;
            end
          end
          // multiply runs in the unit; unknown operators drop the number
          default: ;
        endcase
      end
      S_ARITH_WAIT: begin
        if (alu_sts.done) begin
          last_term_nxt = arith_val;
          err_ovf_nxt   = err_ovf_r | arith_ovf;
        end
      end
      S_FIN: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_value_nxt  = sum_val;
          out_dbz_nxt    = err_div_r;
          out_ovf_nxt    = err_ovf_r | sum_ovf;
          closed_sum_nxt = '0;
          last_term_nxt  = '0;
          mant_nxt       = '0;
          frac_mode_nxt  = 1'b0;
          frac_cnt_nxt   = '0;
          pend_op_nxt    = CH_PLUS;
          err_div_nxt    = 1'b0;
          err_ovf_nxt    = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      closed_sum_r <= '0;
      last_term_r  <= '0;
      mant_r       <= '0;
      frac_mode_r  <= 1'b0;
      frac_cnt_r   <= '0;
      pend_op_r    <= CH_PLUS;
      fin_r        <= 1'b0;
      err_div_r    <= 1'b0;
      err_ovf_r    <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      closed_sum_r <= closed_sum_nxt;
      last_term_r  <= last_term_nxt;
      mant_r       <= mant_nxt;
      frac_mode_r  <= frac_mode_nxt;
      frac_cnt_r   <= frac_cnt_nxt;
      pend_op_r    <= pend_op_nxt;
      fin_r        <= fin_nxt;
      err_div_r    <= err_div_nxt;
      err_ovf_r    <= err_ovf_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    next_op_r   <= next_op_nxt;
    num_r       <= num_nxt;
    neg_r       <= neg_nxt;
    out_value_r <= out_value_nxt;
    out_dbz_r   <= out_dbz_nxt;
    out_ovf_r   <= out_ovf_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_W'(out_value_r);
  assign out_tuser  = {out_ovf_r, out_dbz_r};

  // Unit is only started when free
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    alu_req.start |-> !alu_sts.busy)
    else $error("shared unit started while busy");

  // No character taken while the unit still works
  a_ready_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !alu_sts.busy)
    else $error("input ready during unit operation");

  // Unit results arrive only when the sequencer waits for them
  a_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
    alu_sts.done |-> (state_r == S_CONV_WAIT || state_r == S_ARITH_WAIT))
    else $error("unit result with no waiting state");

  // Finishing loads a result and returns the expression state to its start
  a_fin_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && out_free) |=>
      (out_tvalid && closed_sum_r == '0 && last_term_r == '0 && pend_op_r == CH_PLUS))
    else $error("finish did not post result and clear state");

endmodule

FILE: bench/tb_infix_expression_evaluator.sv
// Self-checking testbench for the infix expression evaluator with a fixed-point predictor.
module tb_infix_expression_evaluator;
  import iee_pkg::*;

  localparam int FRAC_BITS       = 16;
  localparam int VALUE_BITS      = 48;
  localparam int MAX_FRAC_DIGITS = 5;

  localparam longint          VMAX   = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint          VMIN   = -VMAX - 1;
  localparam longint unsigned VMAX_U = 64'h0000_7FFF_FFFF_FFFF;

  // Terminator used to close well-formed expressions
  localparam logic [7:0] CH_EQUAL = 8'h3D;

  localparam int RANDOM_ITEMS = 1020;
  localparam int HOLD_CYCLES  = 3000;
  localparam int DRAIN_CYCLES = 300;

  typedef struct packed {
    logic [VALUE_BITS-1:0] value;
    logic                  div_by_zero;
    logic                  overflow;
  } expr_result_t;

  // Tracks expression state per accepted character and checks each result transfer
  class expr_scoreboard;
    longint          closed_sum;
    longint          last_term;
    bit              have_term;
    longint unsigned mantissa;
    bit              fraction_mode;
    int              fraction_digits;
    logic [7:0]      pending_op;
    bit              div_flag;
    bit              ovf_flag;
    expr_result_t    pending_results[$];
    int              errors;

    function new();
      errors = 0;
      clear_state();
    endfunction

    function void clear_state();
      closed_sum      = 0;
      last_term       = 0;
      have_term       = 0;
      mantissa        = 0;
      fraction_mode   = 0;
      fraction_digits = 0;
      pending_op      = CH_PLUS;
      div_flag        = 0;
      ovf_flag        = 0;
    endfunction

    function longint sat_add(longint a, longint b);
      longint s;
      s = a + b;
      if (s > VMAX) begin
        ovf_flag = 1;
        return VMAX;
      end
      if (s < VMIN) begin
        ovf_flag = 1;
        return VMIN;
      end
      return s;
    endfunction

    function logic [127:0] magnitude(longint a);
      longint unsigned m;
      m = (a < 0) ? -a : a;
      return {64'd0, m};
    endfunction

    // Saturate a magnitude and apply the sign
    function longint from_magnitude(logic [127:0] m, bit neg);
      logic [127:0] lim;
      lim = {64'd0, VMAX_U} + (neg ? 128'd1 : 128'd0);
      if (m > lim) begin
        ovf_flag = 1;
        return neg ? VMIN : VMAX;
      end
      if (neg) return -longint'(m[63:0]);
      return longint'(m[63:0]);
    endfunction

    // Rounded to nearest, ties away from zero
    function longint scaled_product(longint a, longint b);
      logic [127:0] p;
      p = magnitude(a) * magnitude(b) + (128'd1 << (FRAC_BITS - 1));
      return from_magnitude(p >> FRAC_BITS, (a < 0) != (b < 0));
    endfunction

    function longint scaled_quotient(longint a, longint b);
      logic [127:0] n;
      if (b == 0) begin
        div_flag = 1;
        return (a > 0) ? VMAX : ((a < 0) ? VMIN : 0);
      end
      n = (magnitude(a) << FRAC_BITS) + (magnitude(b) >> 1);
      return from_magnitude(n / magnitude(b), (a < 0) != (b < 0));
    endfunction

    // Decimal mantissa over 10^digits to fixed point, ties up
    function longint number_to_fixed();
      longint unsigned scale, whole, rest, v;
      scale = 1;
      repeat (fraction_digits) scale = scale * 10;
      whole = mantissa / scale;
      rest  = mantissa % scale;
      if (whole > (VMAX_U >> FRAC_BITS)) begin
        ovf_flag = 1;
        return VMAX;
      end
      v = (whole << FRAC_BITS) + ((rest << FRAC_BITS) + scale / 2) / scale;
      if (v > VMAX_U) begin
        ovf_flag = 1;
        return VMAX;
      end
      return longint'(v);
    endfunction

    function void push_term(longint v);
      closed_sum = sat_add(closed_sum, last_term);
      last_term  = v;
      have_term  = 1;
    endfunction

    function void close_number(logic [7:0] next_op);
      longint v, prev;
      v    = number_to_fixed();
      prev = have_term ? last_term : 0;
      case (pending_op)
        CH_PLUS:  push_term(v);
        CH_MINUS: push_term(-v);
        CH_STAR: begin
          last_term = scaled_product(prev, v);
          have_term = 1;
        end
        CH_SLASH: begin
          last_term = scaled_quotient(prev, v);
          have_term = 1;
        end
        default: ;
      endcase
      mantissa        = 0;
      fraction_mode   = 0;
      fraction_digits = 0;
      pending_op      = next_op;
    endfunction

    // One accepted input transfer
    function void take_char(logic [7:0] ch, logic fin);
      longint unsigned d;
      longint          total;
      expr_result_t    res;
      if (ch >= CH_ZERO && ch <= CH_NINE) begin
        d = 64'(ch - CH_ZERO);
        if (!fraction_mode || fraction_digits < MAX_FRAC_DIGITS) begin
          if (mantissa > (VMAX_U - d) / 10) begin
            mantissa = VMAX_U;
            ovf_flag = 1;
          end else begin
            mantissa = mantissa * 10 + d;
          end
          if (fraction_mode) fraction_digits++;
        end
      end else if (ch == CH_POINT) begin
        fraction_mode = 1;
      end else begin
        close_number(ch);
      end
      if (fin) begin
        total           = sat_add(closed_sum, last_term);
        res.value       = total[VALUE_BITS-1:0];
        res.div_by_zero = div_flag;
        res.overflow    = ovf_flag;
        pending_results.push_back(res);
        clear_state();
      end
    endfunction

    // One result transfer against the oldest prediction
    function void check_result(logic [VALUE_BITS-1:0] value, logic [1:0] flags);
      expr_result_t want;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: expected none, got value %h flags %b",
                 $time, value, flags);
        return;
      end
      want = pending_results.pop_front();
      if (value !== want.value) begin
        errors++;
        $display("%0t: value mismatch: expected %h, got %h", $time, want.value, value);
      end
      if (flags[0] !== want.div_by_zero) begin
        errors++;
        $display("%0t: div_by_zero mismatch: expected %b, got %b",
                 $time, want.div_by_zero, flags[0]);
      end
      if (flags[1] !== want.overflow) begin
        errors++;
        $display("%0t: overflow mismatch: expected %b, got %b",
                 $time, want.overflow, flags[1]);
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [7:0]            in_tdata;
  logic                  in_tlast;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [VALUE_BITS-1:0] out_tdata;
  logic [1:0]            out_tuser;

  expr_scoreboard sb;
  logic [7:0]     expr_text[$];
  int             items_sent;
  int             send_idle_pct;
  int             recv_idle_pct;
  bit             hold_req;
  bit             hold_done;

  infix_expression_evaluator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Offer one character, with a random gap first, and wait for its transfer
  task automatic send_char(logic [7:0] ch, logic fin);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= ch;
    in_tlast  <= fin;
    do @(posedge clk); while (!in_tready);
    sb.take_char(ch, fin);
    items_sent++;
  endtask

  // Send the built expression, marking its final character
  task automatic send_expr();
    foreach (expr_text[i]) send_char(expr_text[i], i == expr_text.size() - 1);
    expr_text.delete();
  endtask

  task automatic put_text(string s);
    for (int i = 0; i < s.len(); i++) expr_text.push_back(s[i]);
  endtask

  task automatic add_digits(int n);
    repeat (n) expr_text.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
  endtask

  // Mostly short numbers, some very long or empty, some with fractions or a stray second point
  task automatic add_number();
    int kind;
    kind = $urandom_range(0, 99);
    if (kind < 8) return;
    if (kind < 18) add_digits($urandom_range(8, 16));
    else add_digits($urandom_range(1, 3));
    if ($urandom_range(0, 99) < 40) begin
      expr_text.push_back(CH_POINT);
      add_digits($urandom_range(0, 7));
      if ($urandom_range(0, 99) < 5) begin
        expr_text.push_back(CH_POINT);
        add_digits($urandom_range(1, 2));
      end
    end
  endtask

  task automatic build_random_expr();
    int         nterms, r;
    logic [7:0] op;
    expr_text.delete();
    // Noise: arbitrary bytes
    if ($urandom_range(0, 99) < 8) begin
      repeat ($urandom_range(1, 8)) expr_text.push_back(8'($urandom_range(0, 255)));
      return;
    end
    nterms = $urandom_range(1, 5);
    add_number();
    for (int i = 1; i < nterms; i++) begin
      r = $urandom_range(0, 99);
      if (r < 30) op = CH_PLUS;
      else if (r < 50) op = CH_MINUS;
      else if (r < 72) op = CH_STAR;
      else if (r < 95) op = CH_SLASH;
      else op = 8'($urandom_range(0, 255));
      expr_text.push_back(op);
      if (op == CH_SLASH && $urandom_range(0, 99) < 12) expr_text.push_back(CH_ZERO);
      else add_number();
    end
    r = $urandom_range(0, 99);
    if (r < 90) expr_text.push_back(CH_EQUAL);
    else if (r >= 95) expr_text.push_back(8'($urandom_range(0, 255)));
    if (expr_text.size() == 0) add_digits(1);
  endtask

  // Result side: random stalls, plus one long hold-off on request
  initial begin
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser);
      if (hold_req) begin
        hold_req = 0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_tready <= rst_n && ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // Stimulus and end of run
  initial begin
    int guard;
    sb            = new();
    items_sent    = 0;
    send_idle_pct = 21;
    recv_idle_pct = 77;
    hold_req      = 0;
    hold_done     = 0;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= 8'h00;
    in_tlast  <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Zero divisor with zero, positive and negative dividends; '*' with no earlier term
    put_text("*3/0+5/0-5/0=");
    send_expr();
    // Second point, extra fraction digits, unknown operators 0xFF and 0x00
    put_text("1.2.34567*2");
    expr_text.push_back(8'hFF);
    put_text("7+");
    expr_text.push_back(8'h00);
    send_expr();
    // Number still open at the last character
    put_text("3-1");
    send_expr();

    while (items_sent < RANDOM_ITEMS) begin
      if (items_sent >= 700) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
        if (!hold_done) begin
          hold_req  = 1;
          hold_done = 1;
        end
      end else if (items_sent >= 350) begin
        send_idle_pct = 77;
        recv_idle_pct = 21;
      end
      build_random_expr();
      send_expr();
    end
    in_tvalid <= 1'b0;

    guard = 0;
    while (sb.pending_results.size() != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.pending_results.size() != 0) begin
      sb.errors++;
      $display("%0t: %0d expected results never arrived", $time, sb.pending_results.size());
    end
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #6000000;
    $display("Some tests failed");
    $finish;
  end

endmodule
